// ===== rtl/psf_pkg.sv =====
// Package for the steering particle block: widths, command and register codes,
// the shared-unit request type and the saturation helper.
// No dependencies.
`default_nettype none

package psf_pkg;

    // default fraction bits of all Q-format vectors
    localparam int FRAC_BITS_DEF = 16;

    // datapath widths
    localparam int VEC_W  = 32;   // state components and ports
    localparam int MAG_W  = 34;   // working vector / magnitude / quotient
    localparam int SUM_W  = 36;   // sums before saturation
    localparam int LIM_W  = 23;   // force, speed and arrive registers
    localparam int DAMP_W = 17;   // damping register, Q1.16
    localparam int LEN_W  = 35;   // vector length after the shift-back
    localparam int PROD_W = 57;   // magnitude times limit
    localparam int MUL_W  = 66;   // full product of the shared multiplier
    localparam int RAD_W  = 64;   // sum of squares
    localparam int DAMP_SH = 16;  // damping is always Q1.16

    // commands
    localparam logic [2:0] CMD_PLACE = 3'd0;
    localparam logic [2:0] CMD_FORCE = 3'd1;
    localparam logic [2:0] CMD_SEEK  = 3'd2;
    localparam logic [2:0] CMD_FLEE  = 3'd3;
    localparam logic [2:0] CMD_STEP  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FORCE_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_SPEED_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_ARRIVE_RADIUS = 2'd2;
    localparam logic [1:0] CFG_DAMPING       = 2'd3;

    // request to the shared divide / square-root unit
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_unit_req;

    // clamp a wide signed sum into the int32 range
    function automatic logic signed [VEC_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFFFFFF);
        lo = -SUM_W'(33'sh080000000);
        if (v > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[VEC_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psf_iter_unit.sv =====
// Shared iterative unit: restoring divider (one quotient bit per cycle) and
// bit-pair integer square root (one result bit per cycle). Uses psf_pkg.
`default_nettype none

module psf_iter_unit
    import psf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_unit_req         i_req,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [LEN_W-1:0]  i_divisor,
    input  wire logic [RAD_W-1:0]  i_radicand,
    output logic                   o_done,
    output logic [MAG_W-1:0]       o_result
);

    logic              r_busy;
    logic              r_mode;
    logic              r_done;
    logic [5:0]        r_cnt;
    // divider
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_den;
    logic [MAG_W-1:0]  r_low;
    logic [MAG_W-1:0]  r_quo;
    // square root
    logic [RAD_W-1:0]  r_x;
    logic [RAD_W-1:0]  r_res;
    logic [RAD_W-1:0]  r_bit;

    logic [LEN_W:0]    rem_sh;
    logic              div_ge;
    logic [RAD_W:0]    trial;
    logic              sq_ge;

    // one divider step
    assign rem_sh = {r_rem, r_low[MAG_W-1]};
    assign div_ge = (rem_sh >= {1'b0, r_den});
    // one root step
    assign trial  = {1'b0, r_res} + {1'b0, r_bit};
    assign sq_ge  = ({1'b0, r_x} >= trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.sqrt_mode;
                r_cnt  <= i_req.sqrt_mode ? 6'd31 : 6'(MAG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= LEN_W'(i_dividend >> MAG_W);
            r_low <= i_dividend[MAG_W-1:0];
            r_den <= i_divisor;
            r_quo <= '0;
            r_x   <= i_radicand;
            r_res <= '0;
            r_bit <= RAD_W'(1) << 62;
        end else if (r_busy) begin
            if (r_mode) begin
                if (sq_ge) begin
                    r_x   <= r_x - trial[RAD_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                r_rem <= div_ge ? LEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[LEN_W-1:0];
                r_low <= {r_low[MAG_W-2:0], 1'b0};
                r_quo <= {r_quo[MAG_W-2:0], div_ge};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_mode ? r_res[MAG_W-1:0] : r_quo;

endmodule

`default_nettype wire

// ===== rtl/particle_seek_flee_step.sv =====
// One steering particle; a small sequencer drives one multiplier and the
// shared divide / square-root unit (psf_iter_unit). Uses psf_pkg.
// Place, force and unknown commands go straight to the result register; a vector
// length uses the shared square root, each scaled vector component a multiply and
// a divide (the damping a shift); seek/flee and step chain several of these.
// One request at a time: the input stalls until the result is registered.
// Synchronous active-low reset: state vectors zero, limits to 1.0/18.0/5.0, damping 0.98.
`default_nettype none

module particle_seek_flee_step
    import psf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [2:0]              i_command,
    input  wire logic signed [VEC_W-1:0] i_vec_x,
    input  wire logic signed [VEC_W-1:0] i_vec_y,
    input  wire logic signed [VEC_W-1:0] i_vec_z,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [VEC_W-1:0]      o_pos_x,
    output logic signed [VEC_W-1:0]      o_pos_y,
    output logic signed [VEC_W-1:0]      o_pos_z,
    output logic                         o_snapped_home,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [31:0]             i_cfg_data
);

    localparam logic [63:0]      ONE64    = 64'd1 << FRAC_BITS;
    localparam logic [63:0]      SPEED64  = ONE64 * 64'd18;
    localparam logic [63:0]      ARRIVE64 = ONE64 * 64'd5;
    localparam logic [LIM_W-1:0] RST_FORCE  = ONE64[LIM_W-1:0];
    localparam logic [LIM_W-1:0] RST_SPEED  = SPEED64[LIM_W-1:0];
    localparam logic [LIM_W-1:0] RST_ARRIVE = ARRIVE64[LIM_W-1:0];
    localparam logic [DAMP_W-1:0] RST_DAMP  = DAMP_W'(64225);
    localparam logic [LEN_W-1:0] ONE_FIX  = ONE64[LEN_W-1:0];
    localparam logic [MAG_W-1:0] MAG_MAX  = MAG_W'(34'h080000000);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LEN      = 4'd1;
    localparam logic [3:0] S_SHIFT    = 4'd2;
    localparam logic [3:0] S_SQ       = 4'd3;
    localparam logic [3:0] S_ROOT_GO  = 4'd4;
    localparam logic [3:0] S_ROOT     = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_DIV_GO   = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_WB       = 4'd9;
    localparam logic [3:0] S_CONT     = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    // what to do when a length or scaling finishes
    localparam logic [2:0] P_AIM        = 3'd0;
    localparam logic [2:0] P_DESIRED    = 3'd1;
    localparam logic [2:0] P_STEER_LEN  = 3'd2;
    localparam logic [2:0] P_STEER_DONE = 3'd3;
    localparam logic [2:0] P_VEL_LEN    = 3'd4;
    localparam logic [2:0] P_VEL_DONE   = 3'd5;
    localparam logic [2:0] P_DAMP_DONE  = 3'd6;

    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic [2:0]              r_phase;
    logic [2:0]              r_cmd;
    logic                    r_snap;
    logic [1:0]              r_idx;
    logic [1:0]              r_k;

    logic signed [VEC_W-1:0] r_pos  [3];
    logic signed [VEC_W-1:0] r_home [3];
    logic signed [VEC_W-1:0] r_vel  [3];
    logic signed [VEC_W-1:0] r_acc  [3];
    logic signed [MAG_W-1:0] r_w    [3];
    logic [MAG_W-1:0]        r_m    [3];

    logic [LIM_W-1:0]        r_force_lim;
    logic [LIM_W-1:0]        r_speed_lim;
    logic [LIM_W-1:0]        r_arrive;
    logic [DAMP_W-1:0]       r_damp;

    logic [LEN_W-1:0]        r_len;
    logic [RAD_W-1:0]        r_sum;
    logic [MUL_W-1:0]        r_prod;
    logic [LIM_W-1:0]        r_num;
    logic [LEN_W-1:0]        r_den;
    logic                    r_shift_mode;

    logic                    r_out_valid;
    logic signed [VEC_W-1:0] r_out_pos [3];
    logic                    r_out_snap;

    logic signed [VEC_W-1:0] in_vec [3];
    logic                    in_acc;
    logic [MAG_W-1:0]        mul_a;
    logic [31:0]             mul_b;
    logic [MAG_W-1:0]        cur_mag;
    logic                    cur_neg;
    logic [MAG_W-1:0]        quo;
    logic                    any_big;
    t_unit_req               unit_req;
    logic                    unit_done;
    logic [MAG_W-1:0]        unit_res;

    assign in_vec[0] = i_vec_x;
    assign in_vec[1] = i_vec_y;
    assign in_vec[2] = i_vec_z;
    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // element of the working vector picked by the index
    always_comb begin
        case (r_idx)
            2'd0:    cur_neg = r_w[0][MAG_W-1];
            2'd1:    cur_neg = r_w[1][MAG_W-1];
            2'd2:    cur_neg = r_w[2][MAG_W-1];
            default: cur_neg = 1'b0;
        endcase
        case (r_idx)
            2'd0:    cur_mag = r_w[0][MAG_W-1] ? MAG_W'(-r_w[0]) : MAG_W'(r_w[0]);
            2'd1:    cur_mag = r_w[1][MAG_W-1] ? MAG_W'(-r_w[1]) : MAG_W'(r_w[1]);
            2'd2:    cur_mag = r_w[2][MAG_W-1] ? MAG_W'(-r_w[2]) : MAG_W'(r_w[2]);
            default: cur_mag = '0;
        endcase
    end

    // shared multiplier operands: squares of magnitudes or magnitude times a limit or the damping
    always_comb begin
        if (r_state == S_SQ) begin
            case (r_idx)
                2'd0:    mul_b = r_m[0][31:0];
                2'd1:    mul_b = r_m[1][31:0];
                2'd2:    mul_b = r_m[2][31:0];
                default: mul_b = '0;
            endcase
            mul_a = MAG_W'(mul_b);
        end else begin
            mul_a = cur_mag;
            mul_b = 32'(r_num);
        end
    end

    assign any_big = (r_m[0] > MAG_MAX) || (r_m[1] > MAG_MAX) || (r_m[2] > MAG_MAX);
    assign quo     = r_shift_mode ? r_prod[DAMP_SH +: MAG_W] : unit_res;

    assign unit_req.start     = (r_state == S_ROOT_GO) || (r_state == S_DIV_GO);
    assign unit_req.sqrt_mode = (r_state == S_ROOT_GO);

    psf_iter_unit u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (unit_req),
        .i_dividend (r_prod[PROD_W-1:0]),
        .i_divisor  (r_den),
        .i_radicand (r_sum),
        .o_done     (unit_done),
        .o_result   (unit_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_SEEK, CMD_FLEE, CMD_STEP: n_state = S_LEN;
                        default:                      n_state = S_OUT;
                    endcase
                end
            end
            S_LEN:     n_state = S_SHIFT;
            S_SHIFT:   n_state = any_big ? S_SHIFT : S_SQ;
            S_SQ:      n_state = (r_idx == 2'd3) ? S_ROOT_GO : S_SQ;
            S_ROOT_GO: n_state = S_ROOT;
            S_ROOT:    n_state = unit_done ? S_CONT : S_ROOT;
            S_MUL:     n_state = r_shift_mode ? S_WB : S_DIV_GO;
            S_DIV_GO:  n_state = S_DIV;
            S_DIV:     n_state = unit_done ? S_WB : S_DIV;
            S_WB:      n_state = (r_idx == 2'd2) ? S_CONT : S_MUL;
            S_CONT: begin
                case (r_phase)
                    P_AIM: begin
                        if (r_cmd == CMD_SEEK && r_len < LEN_W'(r_arrive) && r_len < ONE_FIX) begin
                            n_state = S_OUT;
                        end else if (r_cmd == CMD_SEEK && r_len < LEN_W'(r_arrive)) begin
                            n_state = S_MUL;
                        end else if (r_len == '0) begin
                            n_state = S_CONT;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                    P_DESIRED:    n_state = S_LEN;
                    P_STEER_LEN:  n_state = (r_len > LEN_W'(r_force_lim)) ? S_MUL : S_CONT;
                    P_STEER_DONE: n_state = S_OUT;
                    P_VEL_LEN:    n_state = (r_len > LEN_W'(r_speed_lim)) ? S_MUL : S_CONT;
                    P_VEL_DONE:   n_state = S_MUL;
                    P_DAMP_DONE:  n_state = S_OUT;
                    default:      n_state = S_OUT;
                endcase
            end
            S_OUT:   n_state = (!r_out_valid || !i_out_stall) ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_AIM;
            r_cmd       <= CMD_PLACE;
            r_snap      <= 1'b0;
            r_idx       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_force_lim <= RST_FORCE;
            r_speed_lim <= RST_SPEED;
            r_arrive    <= RST_ARRIVE;
            r_damp      <= RST_DAMP;
            for (int i = 0; i < 3; i++) begin
                r_pos[i]  <= '0;
                r_home[i] <= '0;
                r_vel[i]  <= '0;
                r_acc[i]  <= '0;
            end
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FORCE_LIMIT:   r_force_lim <= i_cfg_data[LIM_W-1:0];
                    CFG_SPEED_LIMIT:   r_speed_lim <= i_cfg_data[LIM_W-1:0];
                    CFG_ARRIVE_RADIUS: r_arrive    <= i_cfg_data[LIM_W-1:0];
                    CFG_DAMPING:       r_damp      <= i_cfg_data[DAMP_W-1:0];
                    default: ;
                endcase
            end

            // result register: load a finished request, else drain when taken
            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd  <= i_command;
                        r_snap <= 1'b0;
                        case (i_command)
                            CMD_PLACE: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_pos[i]  <= in_vec[i];
                                    r_home[i] <= in_vec[i];
                                end
                            end
                            CMD_FORCE: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_acc[i] <= sat32(SUM_W'(r_acc[i]) + SUM_W'(in_vec[i]));
                                end
                            end
                            CMD_SEEK, CMD_FLEE: begin
                                r_phase <= P_AIM;
                            end
                            CMD_STEP: begin
                                r_phase <= P_VEL_LEN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LEN: begin
                    r_k <= '0;
                end
                S_SHIFT: begin
                    if (any_big) begin
                        r_k <= r_k + 2'd1;
                    end else begin
                        r_idx <= '0;
                    end
                end
                S_SQ: begin
                    r_idx <= r_idx + 2'd1;
                end
                S_ROOT: begin
                    if (unit_done) begin
                        r_len <= LEN_W'(unit_res) << r_k;
                    end
                end
                S_WB: begin
                    r_idx <= r_idx + 2'd1;
                end
                S_CONT: begin
                    r_idx <= '0;
                    case (r_phase)
                        P_AIM: begin
                            if (r_cmd == CMD_SEEK && r_len < LEN_W'(r_arrive)
                                    && r_len < ONE_FIX) begin
                                r_snap <= 1'b1;
                                for (int i = 0; i < 3; i++) begin
                                    r_pos[i] <= r_home[i];
                                end
                            end else begin
                                r_phase <= P_DESIRED;
                            end
                        end
                        P_DESIRED:   r_phase <= P_STEER_LEN;
                        P_STEER_LEN: r_phase <= P_STEER_DONE;
                        P_STEER_DONE: begin
                            for (int i = 0; i < 3; i++) begin
                                r_acc[i] <= sat32(SUM_W'(r_acc[i]) + ((r_cmd == CMD_FLEE) ?
                                            -SUM_W'(r_w[i]) : SUM_W'(r_w[i])));
                            end
                        end
                        P_VEL_LEN: r_phase <= P_VEL_DONE;
                        P_VEL_DONE: begin
                            r_phase <= P_DAMP_DONE;
                            for (int i = 0; i < 3; i++) begin
                                r_pos[i] <= sat32(SUM_W'(r_pos[i]) + SUM_W'(r_w[i]));
                                r_acc[i] <= '0;
                            end
                        end
                        P_DAMP_DONE: begin
                            for (int i = 0; i < 3; i++) begin
                                r_vel[i] <= sat32(SUM_W'(r_w[i]));
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // working datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    for (int i = 0; i < 3; i++) begin
                        if (i_command == CMD_STEP) begin
                            r_w[i] <= MAG_W'(sat32(SUM_W'(r_vel[i]) + SUM_W'(r_acc[i])));
                        end else begin
                            r_w[i] <= MAG_W'(in_vec[i]) - MAG_W'(r_pos[i]);
                        end
                    end
                end
            end
            S_LEN: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i] <= r_w[i][MAG_W-1] ? MAG_W'(-r_w[i]) : MAG_W'(r_w[i]);
                end
                r_sum <= '0;
            end
            S_SHIFT: begin
                if (any_big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] >> 1;
                    end
                end
            end
            // square one magnitude per cycle, add the previous square
            S_SQ: begin
                r_prod <= MUL_W'(mul_a) * MUL_W'(mul_b);
                if (r_idx != 2'd0) begin
                    r_sum <= r_sum + r_prod[RAD_W-1:0];
                end
            end
            S_MUL: begin
                r_prod <= MUL_W'(mul_a) * MUL_W'(mul_b);
            end
            S_WB: begin
                case (r_idx)
                    2'd0:    r_w[0] <= cur_neg ? -$signed(quo) : $signed(quo);
                    2'd1:    r_w[1] <= cur_neg ? -$signed(quo) : $signed(quo);
                    2'd2:    r_w[2] <= cur_neg ? -$signed(quo) : $signed(quo);
                    default: ;
                endcase
            end
            // set up the next scaling or vector update
            S_CONT: begin
                r_shift_mode <= 1'b0;
                case (r_phase)
                    P_AIM: begin
                        r_num <= r_speed_lim;
                        if (r_cmd == CMD_SEEK && r_len < LEN_W'(r_arrive)) begin
                            r_den <= LEN_W'(r_arrive);
                        end else begin
                            r_den <= r_len;
                            if (r_len == '0) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_w[i] <= '0;
                                end
                            end
                        end
                    end
                    P_DESIRED: begin
                        for (int i = 0; i < 3; i++) begin
                            r_w[i] <= r_w[i] - MAG_W'(r_vel[i]);
                        end
                    end
                    P_STEER_LEN: begin
                        r_num <= r_force_lim;
                        r_den <= r_len;
                    end
                    P_VEL_LEN: begin
                        r_num <= r_speed_lim;
                        r_den <= r_len;
                    end
                    P_VEL_DONE: begin
                        r_num        <= LIM_W'(r_damp);
                        r_shift_mode <= 1'b1;
                    end
                    default: ;
                endcase
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    for (int i = 0; i < 3; i++) begin
                        r_out_pos[i] <= r_pos[i];
                    end
                    r_out_snap <= r_snap;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_pos_x        = r_out_pos[0];
    assign o_pos_y        = r_out_pos[1];
    assign o_pos_z        = r_out_pos[2];
    assign o_snapped_home = r_out_snap;

    // a taken request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted request did not start work");

    // only a seek can report a snap
    a_snap_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_snap) |-> (r_cmd == CMD_SEEK))
        else $error("snap flagged outside seek");

    // length pre-shift never exceeds two bits
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_k != 2'd3))
        else $error("length shift out of range");

    // writeback index stays within the vector
    a_wb_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> (r_idx != 2'd3))
        else $error("writeback index out of range");

    // the shared unit is never restarted while a result is awaited
    a_unit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_ROOT) |-> !unit_req.start)
        else $error("shared unit restarted while busy");

endmodule

`default_nettype wire

// ===== verif/psf_checker.sv =====
// Checker for particle_seek_flee_step: follows the config, input and output channels,
// predicts each particle position and compares it with the block's result.
// Depends on psf_pkg.
`timescale 1ns / 100ps

module psf_checker
    import psf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire logic [2:0]              i_command,
    input  wire logic signed [VEC_W-1:0] i_vec_x,
    input  wire logic signed [VEC_W-1:0] i_vec_y,
    input  wire logic signed [VEC_W-1:0] i_vec_z,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic signed [VEC_W-1:0] i_pos_x,
    input  wire logic signed [VEC_W-1:0] i_pos_y,
    input  wire logic signed [VEC_W-1:0] i_pos_z,
    input  wire logic                    i_snapped_home,
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [31:0]             i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        logic                    snap;
    } t_pos_rec;

    // particle state, kept wide like the arithmetic it follows
    longint pos_q [3];
    longint home_q [3];
    longint vel_q [3];
    longint acc_q [3];
    longint unsigned lim_force;
    longint unsigned lim_speed;
    longint unsigned radius;
    longint unsigned damp;

    t_pos_rec pos_expect_q [$];

    function automatic longint sat_i32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // length with a common pre-shift so the squares fit 64 bits
    function automatic longint unsigned len3(input longint a, input longint b, input longint c);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mc;
        int k;
        ma = magn(a);
        mb = magn(b);
        mc = magn(c);
        k  = 0;
        while (ma > 64'h80000000 || mb > 64'h80000000 || mc > 64'h80000000) begin
            ma = ma >> 1;
            mb = mb >> 1;
            mc = mc >> 1;
            k++;
        end
        return root64(ma * ma + mb * mb + mc * mc) << k;
    endfunction

    // truncating scale toward zero
    function automatic longint scale_c(input longint c, input longint unsigned num,
                                       input longint unsigned den);
        longint unsigned r;
        r = magn(c) * num / den;
        return (c < 0) ? -longint'(r) : longint'(r);
    endfunction

    // seek / flee steering; returns 1 when the particle snapped home
    function automatic bit steer_toward(input longint tx, input longint ty, input longint tz,
                                        input bit flee);
        longint d [3];
        longint st [3];
        longint unsigned tgt_len;
        longint unsigned slen;
        d[0] = tx - pos_q[0];
        d[1] = ty - pos_q[1];
        d[2] = tz - pos_q[2];
        tgt_len = len3(d[0], d[1], d[2]);
        if (!flee && tgt_len < radius) begin
            if (tgt_len < (64'd1 << FRAC_BITS_DEF)) begin
                for (int i = 0; i < 3; i++) pos_q[i] = home_q[i];
                return 1'b1;
            end
            for (int i = 0; i < 3; i++) d[i] = scale_c(d[i], lim_speed, radius);
        end else if (tgt_len == 0) begin
            for (int i = 0; i < 3; i++) d[i] = 0;
        end else begin
            for (int i = 0; i < 3; i++) d[i] = scale_c(d[i], lim_speed, tgt_len);
        end
        for (int i = 0; i < 3; i++) st[i] = d[i] - vel_q[i];
        slen = len3(st[0], st[1], st[2]);
        if (slen > lim_force)
            for (int i = 0; i < 3; i++) st[i] = scale_c(st[i], lim_force, slen);
        for (int i = 0; i < 3; i++) begin
            if (flee) st[i] = -st[i];
            acc_q[i] = sat_i32(acc_q[i] + st[i]);
        end
        return 1'b0;
    endfunction

    function automatic t_pos_rec predict_pos(input logic [2:0] cmd, input longint vx,
                                             input longint vy, input longint vz);
        t_pos_rec rec;
        longint v [3];
        longint unsigned vlen;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        rec.snap = 1'b0;
        case (cmd)
            CMD_PLACE: begin
                for (int i = 0; i < 3; i++) begin
                    pos_q[i]  = v[i];
                    home_q[i] = v[i];
                end
            end
            CMD_FORCE: begin
                for (int i = 0; i < 3; i++) acc_q[i] = sat_i32(acc_q[i] + v[i]);
            end
            CMD_SEEK: rec.snap = steer_toward(vx, vy, vz, 1'b0);
            CMD_FLEE: rec.snap = steer_toward(vx, vy, vz, 1'b1) & 1'b0;
            CMD_STEP: begin
                for (int i = 0; i < 3; i++) vel_q[i] = sat_i32(vel_q[i] + acc_q[i]);
                vlen = len3(vel_q[0], vel_q[1], vel_q[2]);
                if (vlen > lim_speed)
                    for (int i = 0; i < 3; i++) vel_q[i] = scale_c(vel_q[i], lim_speed, vlen);
                for (int i = 0; i < 3; i++) begin
                    pos_q[i] = sat_i32(pos_q[i] + vel_q[i]);
                    acc_q[i] = 0;
                    vel_q[i] = sat_i32(scale_c(vel_q[i], damp, 64'd65536));
                end
            end
            default: ;
        endcase
        rec.x = pos_q[0][VEC_W-1:0];
        rec.y = pos_q[1][VEC_W-1:0];
        rec.z = pos_q[2][VEC_W-1:0];
        return rec;
    endfunction

    // watch all three channels on each edge
    always @(posedge i_clk) begin
        t_pos_rec want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                pos_q[i]  = 0;
                home_q[i] = 0;
                vel_q[i]  = 0;
                acc_q[i]  = 0;
            end
            lim_force    = 65536;
            lim_speed    = 1179648;
            radius       = 327680;
            damp         = 64225;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FORCE_LIMIT:   lim_force = i_cfg_data[LIM_W-1:0];
                    CFG_SPEED_LIMIT:   lim_speed = i_cfg_data[LIM_W-1:0];
                    CFG_ARRIVE_RADIUS: radius    = i_cfg_data[LIM_W-1:0];
                    CFG_DAMPING:       damp      = i_cfg_data[DAMP_W-1:0];
                    default: ;
                endcase
            end
            // results first: they belong to older requests
            if (i_out_valid && !i_out_stall) begin
                if (pos_expect_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("mismatch: unexpected result %h %h %h snap %b",
                                 i_pos_x, i_pos_y, i_pos_z, i_snapped_home);
                end else begin
                    want = pos_expect_q.pop_front();
                    if (want.x !== i_pos_x || want.y !== i_pos_y || want.z !== i_pos_z ||
                        want.snap !== i_snapped_home) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp %h %h %h snap %b, got %h %h %h snap %b",
                                     want.x, want.y, want.z, want.snap,
                                     i_pos_x, i_pos_y, i_pos_z, i_snapped_home);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pos_expect_q.push_back(predict_pos(i_command, longint'(i_vec_x),
                                                   longint'(i_vec_y), longint'(i_vec_z)));
        end
        o_pending = pos_expect_q.size();
    end

endmodule

// ===== verif/tb_particle_seek_flee_step.sv =====
// Testbench top for particle_seek_flee_step: clock, reset, config phases, directed and
// random requests, output stalls and the verdict. Depends on psf_pkg and psf_checker.
`timescale 1ns / 100ps

module tb_particle_seek_flee_step;
    import psf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ONE            = 65536;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [2:0]              i_command = CMD_PLACE;
    logic signed [VEC_W-1:0] i_vec_x = '0;
    logic signed [VEC_W-1:0] i_vec_y = '0;
    logic signed [VEC_W-1:0] i_vec_z = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [VEC_W-1:0] o_pos_x;
    logic signed [VEC_W-1:0] o_pos_y;
    logic signed [VEC_W-1:0] o_pos_z;
    logic                    o_snapped_home;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index = CFG_FORCE_LIMIT;
    logic [31:0]             i_cfg_data = '0;

    int fail_count;
    int pending;
    bit quiet = 1'b0;        // no idling on either side
    int hold_req_cnt = 0;
    int hold_done_cnt = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    logic signed [VEC_W-1:0] home_x = '0;
    logic signed [VEC_W-1:0] home_y = '0;
    logic signed [VEC_W-1:0] home_z = '0;

    always #5 i_clk = ~i_clk;

    particle_seek_flee_step dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_command, .i_vec_x, .i_vec_y, .i_vec_z,
        .o_out_valid, .i_out_stall, .o_pos_x, .o_pos_y, .o_pos_z, .o_snapped_home,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    psf_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_command,
        .i_vec_x, .i_vec_y, .i_vec_z, .i_out_valid(o_out_valid), .i_out_stall,
        .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_pos_z(o_pos_z),
        .i_snapped_home(o_snapped_home), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_done_cnt != hold_req_cnt) begin
            hold_done_cnt <= hold_req_cnt;
            hold_left     <= HOLD_CYCLES;
            i_out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 25);
        end
    end

    // watchdog on cycles without any accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic signed [VEC_W-1:0] near_val(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_req(input logic [2:0] cmd, input logic signed [VEC_W-1:0] x,
                            input logic signed [VEC_W-1:0] y, input logic signed [VEC_W-1:0] z);
        if (!quiet && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_vec_x    <= x;
        i_vec_y    <= y;
        i_vec_z    <= z;
        if (cmd == CMD_PLACE) begin
            home_x = x;
            home_y = y;
            home_z = z;
        end
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input int force_l, input int speed_l, input int rad, input int dmp);
        write_reg(CFG_FORCE_LIMIT, force_l);
        write_reg(CFG_SPEED_LIMIT, speed_l);
        write_reg(CFG_ARRIVE_RADIUS, rad);
        write_reg(CFG_DAMPING, dmp);
    endtask

    // mostly well-formed particle traffic, some full-range and unknown commands
    task automatic random_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_req(CMD_PLACE, near_val(8 * ONE), near_val(8 * ONE), near_val(8 * ONE));
        else if (r < 20)
            send_req(CMD_FORCE, near_val(4 * ONE), near_val(4 * ONE), near_val(4 * ONE));
        else if (r < 32)
            send_req(CMD_SEEK, home_x + near_val(ONE), home_y + near_val(ONE),
                     home_z + near_val(ONE));
        else if (r < 45)
            send_req(CMD_SEEK, near_val(16 * ONE), near_val(16 * ONE), near_val(16 * ONE));
        else if (r < 58)
            send_req(CMD_FLEE, near_val(16 * ONE), near_val(16 * ONE), near_val(16 * ONE));
        else if (r < 88)
            send_req(CMD_STEP, $urandom, $urandom, $urandom);
        else if (r < 95)
            send_req(3'($urandom_range(CMD_PLACE, CMD_STEP)), $urandom, $urandom, $urandom);
        else
            send_req(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
    endtask

    initial begin
        int fl;
        int sl;
        int ar;
        int dm;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, snap, ramp, zero-distance flee, unknown codes
        send_req(CMD_PLACE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_req(CMD_PLACE, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_req(CMD_FORCE, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        send_req(CMD_FORCE, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        send_req(CMD_STEP, 0, 0, 0);
        send_req(CMD_SEEK, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_req(CMD_FLEE, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        send_req(CMD_STEP, 0, 0, 0);
        send_req(CMD_PLACE, 0, 0, 0);
        send_req(CMD_SEEK, 0, 0, 0);
        send_req(CMD_SEEK, ONE / 2, 0, 0);
        send_req(CMD_SEEK, 3 * ONE, 0, 0);
        send_req(CMD_STEP, 0, 0, 0);
        send_req(CMD_SEEK, 100 * ONE, -7 * ONE, 2 * ONE);
        send_req(CMD_STEP, 0, 0, 0);
        send_req(CMD_FLEE, o_pos_x, o_pos_y, o_pos_z);
        send_req(CMD_FLEE, -10 * ONE, 5 * ONE, 2 * ONE);
        send_req(CMD_STEP, 0, 0, 0);
        send_req(3'd5, 32'sh7FFFFFFF, 0, 0);
        send_req(3'd6, 0, 32'sh80000000, 0);
        send_req(3'd7, 0, 0, 32'shFFFFFFFF);
        send_req(CMD_SEEK, 0, 0, 0);
        drain();

        // place exactly on the flee target: zero distance for flee
        send_req(CMD_PLACE, 2 * ONE, 2 * ONE, 2 * ONE);
        send_req(CMD_FLEE, 2 * ONE, 2 * ONE, 2 * ONE);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin fl = 65536;   sl = 1179648; ar = 327680;  dm = 64225;  end
                1: begin fl = 0;       sl = 0;       ar = 65536;   dm = 0;      end
                2: begin fl = 4194304; sl = 4194304; ar = 4194304; dm = 65536;  end
                3: begin fl = 131072;  sl = 655360;  ar = 0;       dm = 131071; end
                4: begin
                    fl = $urandom_range(0, 4194304);
                    sl = $urandom_range(0, 4194304);
                    ar = $urandom_range(65536, 4194304);
                    dm = $urandom_range(0, 65536);
                end
                default: begin fl = 65536; sl = 1179648; ar = 327680; dm = 64225; end
            endcase
            set_limits(fl, sl, ar, dm);
            for (int n = 0; n < 85; n++) begin
                if (phase == 2 && n == 0) quiet <= 1'b1;
                if (phase == 3 && n == 0) quiet <= 1'b0;
                if (phase == 4 && n == 40) hold_req_cnt <= hold_req_cnt + 1;
                if (phase == 1 && n == 40) drain();
                random_req();
            end
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/psf_pkg.sv
rtl/psf_iter_unit.sv
rtl/particle_seek_flee_step.sv
verif/psf_checker.sv
verif/tb_particle_seek_flee_step.sv
